@@ design/bitmap_buffer_allocator_macros.svh @@
// Assertion macros shared by the bitmap buffer allocator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef BITMAP_BUFFER_ALLOCATOR_MACROS_SVH
`define BITMAP_BUFFER_ALLOCATOR_MACROS_SVH

// Check a property on every rising edge outside reset.
`define BBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a signal holds in the cycle after a condition.
`define BBA_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

@@ design/bba_pkg.sv @@
// Shared types and constants of the bitmap buffer allocator.
// No dependencies; imported by the controller, datapath and top level.
package bba_pkg;

    localparam int WORD_BITS      = 64;
    localparam int BIT_W          = 6;
    localparam int MAP_WORDS_DEF  = 4;
    localparam int MAX_PIECES_DEF = 64;

    localparam int LEN_W      = 32;
    localparam int LIMIT_W    = 7;
    localparam int SIZE_W     = 21;
    localparam int OFS_W      = 16;
    localparam int ADDR_W     = 32;
    localparam int INDEX_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 96;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE   = 2'd2;

    localparam logic [SIZE_W-1:0] BUFFER_SIZE_RST = 21'd4096;

    // Commands from controller to datapath
    typedef struct packed {
        logic start;     // latch a new request
        logic claim;     // claim one buffer or flag a full map
        logic mul;       // form size times index
        logic load_out;  // load the output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic last;      // the piece in flight ends the request
    } t_status;

endpackage

@@ design/bba_ctrl.sv @@
// Sequencer of the bitmap buffer allocator: request intake, per-piece steps,
// output valid. Depends on bba_pkg.
module bba_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    input  logic             i_m_ready,
    input  bba_pkg::t_status i_status,
    output logic             o_s_ready,
    output logic             o_m_valid,
    output bba_pkg::t_cmd    o_cmd
);
    import bba_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CLAIM = 2'd1;
    localparam logic [1:0] S_MUL   = 2'd2;
    localparam logic [1:0] S_ADDR  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_m_valid, n_m_valid;
    logic       out_free;

    assign out_free = !r_m_valid || i_m_ready;

    // Step through claim, multiply and address for each piece
    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid && !i_m_ready;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_CLAIM;
                end
            end
            S_CLAIM: begin
                o_cmd.claim = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADDR;
            end
            S_ADDR: begin
                // wait for the output register to free up
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = i_status.last ? S_IDLE : S_CLAIM;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;

endmodule

@@ design/bba_datapath.sv @@
// Datapath of the bitmap buffer allocator: free map, config registers,
// piece arithmetic, address multiply and output register. Depends on bba_pkg.
module bba_datapath #(
    parameter int MAP_WORDS  = bba_pkg::MAP_WORDS_DEF,
    parameter int MAX_PIECES = bba_pkg::MAX_PIECES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bba_pkg::t_cmd                    i_cmd,
    output bba_pkg::t_status                 o_status,
    input  logic                             i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [bba_pkg::LEN_W-1:0]        i_len,
    input  logic [bba_pkg::LIMIT_W-1:0]      i_limit,
    output logic                             o_granted,
    output logic [bba_pkg::INDEX_W-1:0]      o_index,
    output logic [bba_pkg::ADDR_W-1:0]       o_addr,
    output logic [bba_pkg::SIZE_W-1:0]       o_piece,
    output logic [bba_pkg::LEN_W-1:0]        o_rem,
    output logic                             o_last
);
    import bba_pkg::*;

    localparam int WORD_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W  = WORD_W + BIT_W;
    localparam int PROD_W = SIZE_W + IDX_W;
    localparam int CNT_W  = $clog2(MAX_PIECES + 1);

    // Lowest clear bit: per-byte search, then lowest non-full byte
    function automatic logic [BIT_W-1:0] ffz(input logic [WORD_BITS-1:0] w);
        logic [7:0] grp_full;
        logic [2:0] bpos [8];
        logic [2:0] sel;
        for (int g = 0; g < 8; g++) begin
            grp_full[g] = &w[g*8 +: 8];
            bpos[g]     = 3'd0;
            for (int k = 7; k >= 0; k--) begin
                if (!w[g*8 + k]) begin
                    bpos[g] = 3'(k);
                end
            end
        end
        sel = 3'd0;
        for (int g = 7; g >= 0; g--) begin
            if (!grp_full[g]) begin
                sel = 3'(g);
            end
        end
        return {sel, bpos[sel]};
    endfunction

    // Config registers
    logic [ADDR_W-1:0] r_base;
    logic [OFS_W-1:0]  r_ofs;
    logic [SIZE_W-1:0] r_size;

    // Free map: words below r_word are full, words above are untouched
    logic [WORD_W-1:0]    r_word;
    logic [WORD_BITS-1:0] r_cur;
    logic                 r_full;

    // Request and piece state
    logic [LEN_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_limit;
    logic [IDX_W-1:0]  r_idx;
    logic [SIZE_W-1:0] r_piece;
    logic              r_granted;
    logic              r_last;
    logic [PROD_W-1:0] r_prod;

    // Output register
    logic               r_o_granted;
    logic [INDEX_W-1:0] r_o_index;
    logic [ADDR_W-1:0]  r_o_addr;
    logic [SIZE_W-1:0]  r_o_piece;
    logic [LEN_W-1:0]   r_o_rem;
    logic               r_o_last;

    logic [BIT_W-1:0]     bit_pos;
    logic [WORD_BITS-1:0] cur_set;
    logic                 word_done;
    logic                 last_word;
    logic [SIZE_W-1:0]    piece;
    logic [LEN_W-1:0]     rem;
    logic [CNT_W-1:0]     cnt_inc;
    logic                 piece_last;
    logic [CNT_W-1:0]     limit_clamp;

    // Claim arithmetic for the current piece
    always_comb begin
        bit_pos    = ffz(r_cur);
        cur_set    = r_cur | (WORD_BITS'(1) << bit_pos);
        word_done  = &cur_set;
        last_word  = (r_word == WORD_W'(MAP_WORDS - 1));
        piece      = (r_len < LEN_W'(r_size)) ? r_len[SIZE_W-1:0] : r_size;
        rem        = r_len - LEN_W'(piece);
        cnt_inc    = r_cnt + CNT_W'(1);
        piece_last = (rem == '0) || (cnt_inc >= r_limit) || (word_done && last_word);
        if ((i_limit == '0) || (i_limit > LIMIT_W'(MAX_PIECES))) begin
            limit_clamp = CNT_W'(MAX_PIECES);
        end else begin
            limit_clamp = i_limit[CNT_W-1:0];
        end
    end

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_ofs  <= '0;
            r_size <= BUFFER_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POOL_BASE:     r_base <= i_cfg_data;
                CFG_HEADER_OFFSET: r_ofs  <= i_cfg_data[OFS_W-1:0];
                CFG_BUFFER_SIZE:   r_size <= i_cfg_data[SIZE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Mark the claimed bit, advance to the next word when one fills
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
            r_cur  <= '0;
            r_full <= 1'b0;
            r_last <= 1'b0;
        end else if (i_cmd.claim) begin
            if (r_full) begin
                r_last <= 1'b1;
            end else begin
                r_last <= piece_last;
                if (word_done) begin
                    if (last_word) begin
                        r_full <= 1'b1;
                        r_cur  <= cur_set;
                    end else begin
                        r_word <= r_word + WORD_W'(1);
                        r_cur  <= '0;
                    end
                end else begin
                    r_cur <= cur_set;
                end
            end
        end
    end

    // Request latch, piece registers, multiply and output load
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_len   <= i_len;
            r_cnt   <= '0;
            r_limit <= limit_clamp;
        end
        if (i_cmd.claim) begin
            if (r_full) begin
                r_granted <= 1'b0;
                r_idx     <= '0;
                r_piece   <= '0;
            end else begin
                r_granted <= 1'b1;
                r_idx     <= {r_word, bit_pos};
                r_piece   <= piece;
                r_len     <= rem;
                r_cnt     <= cnt_inc;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_size) * PROD_W'(r_idx);
        end
        if (i_cmd.load_out) begin
            r_o_granted <= r_granted;
            r_o_index   <= INDEX_W'(r_idx);
            r_o_addr    <= r_granted ? (r_base + ADDR_W'(r_ofs) + ADDR_W'(r_prod)) : '0;
            r_o_piece   <= r_piece;
            r_o_rem     <= r_len;
            r_o_last    <= r_last;
        end
    end

    assign o_status.last = r_last;
    assign o_granted     = r_o_granted;
    assign o_index       = r_o_index;
    assign o_addr        = r_o_addr;
    assign o_piece       = r_o_piece;
    assign o_rem         = r_o_rem;
    assign o_last        = r_o_last;

endmodule

@@ design/bitmap_buffer_allocator.sv @@
// Top level of the bitmap buffer allocator: stream ports, config port,
// controller and datapath. Depends on bba_pkg, bba_ctrl and bba_datapath.
//
// Usage:
//   A request (length, piece limit) is a transfer on the s_axis channel.
//   The block claims the lowest free buffers of its map one by one and sends
//   one result per buffer on m_axis; tlast marks the final result of a
//   request, tuser is the grant flag (low only when the map was full).
//   Config writes (pool base, header offset, buffer size) use the cfg
//   channel, which is always ready; write only while no request is open.
//   After the request transfer each piece passes the claim, multiply and
//   address-add steps in turn; the next piece of a request is claimed only
//   after the previous one has been loaded into the output register.
//   The next request is taken once the final result sits in the output
//   register, even if the receiver has not yet taken it.
//   Receiver stall: the output register holds; the sequencer waits at the
//   address step until the register frees, so nothing is lost.
//   Reset: every buffer is free, buffer size is 4096, base and offset zero.
module bitmap_buffer_allocator #(
    parameter int MAP_WORDS  = bba_pkg::MAP_WORDS_DEF,
    parameter int MAX_PIECES = bba_pkg::MAX_PIECES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] request_length, [38:32] max_pieces, [39] zero
    input  logic [bba_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] buffer_index, [39:8] buffer_address, [60:40] piece_length,
    // [92:61] remaining_length, [95:93] zero
    output logic [bba_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] granted
    output logic [0:0]                     m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bba_pkg::*;

    t_cmd              cmd;
    t_status           status;
    logic              granted;
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] piece;
    logic [LEN_W-1:0]  rem;

    bba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_status  (status),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (cmd)
    );

    bba_datapath #(
        .MAP_WORDS  (MAP_WORDS),
        .MAX_PIECES (MAX_PIECES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_len       (s_axis_tdata[LEN_W-1:0]),
        .i_limit     (s_axis_tdata[LEN_W +: LIMIT_W]),
        .o_granted   (granted),
        .o_index     (index),
        .o_addr      (addr),
        .o_piece     (piece),
        .o_rem       (rem),
        .o_last      (m_axis_tlast)
    );

    // Pack result fields, lowest field first
    assign m_axis_tdata = {3'b000, rem, piece, addr, index};
    assign m_axis_tuser = granted;
    assign o_cfg_ready  = 1'b1;

endmodule

@@ design/bba_checker.sv @@
// Port-level checker for the bitmap buffer allocator, bound to the top level.
// Depends on bitmap_buffer_allocator_macros.svh.
`include "bitmap_buffer_allocator_macros.svh"

module bba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A result without grant always closes its request
    `BBA_ASSERT(a_nogrant_last, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast, "no-grant result without tlast")

    // A result without grant carries zero index, address and piece length
    `BBA_ASSERT(a_nogrant_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[60:0] == 61'd0), "no-grant result with nonzero fields")

    // No new request is taken while a request still has pieces to send
    `BBA_ASSERT(a_busy_mid_request, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready, "request taken mid request")

    // A stalled result holds its payload
    `BBA_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tdata, "stalled result changed")

endmodule

bind bitmap_buffer_allocator bba_checker u_bba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ dv/bitmap_buffer_allocator_test.sv @@
// Self-checking bench for bitmap_buffer_allocator: directed table, then random requests.
// Depends on bba_pkg and the RTL; carries its own free-map predictor.

module bitmap_buffer_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_ITEMS    = 145;
    localparam int POOL_BUFFERS   = MAP_WORDS_DEF * WORD_BITS;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One result of the block, widths as on the ports
    typedef struct packed {
        logic                granted;
        logic [INDEX_W-1:0]  index;
        logic [ADDR_W-1:0]   address;
        logic [SIZE_W-1:0]   length;
        logic [LEN_W-1:0]    remaining;
        logic                last;
    } t_piece;

    typedef enum logic {ROW_REQUEST, ROW_REGISTER} t_row_kind;

    // Directed stimulus row; want is only used when typed is set
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [31:0]           value;
        logic [LIMIT_W-1:0]    pieces;
        logic                  typed;
        t_piece                want;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predictor state
    logic [WORD_BITS-1:0] used_map [MAP_WORDS_DEF];
    logic [ADDR_W-1:0]    cur_pool_base;
    logic [OFS_W-1:0]     cur_header_ofs;
    logic [SIZE_W-1:0]    cur_buffer_size;
    int                   free_buffers;
    t_piece               pending_pieces [$];

    t_stim_row directed_rows [$];
    int        tx_idle_pct;
    int        rx_idle_pct;
    logic      long_hold_req;
    logic      long_hold_done;
    int        hold_left;
    bit        fill_forced;

    int error_count;
    int requests_sent;
    int grants_checked;
    int full_replies;
    int cfg_writes;

    bitmap_buffer_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Claim the lowest free buffers word by word and, if record is set, queue the resulting pieces
    task automatic claim_buffers(input logic [LEN_W-1:0] len, input logic [LIMIT_W-1:0] pieces,
                                 input bit record);
        logic [LEN_W-1:0] left;
        logic [LEN_W-1:0] piece;
        logic [31:0]      idx;
        int               limit;
        int               n;
        int               b;
        bit               done;
        t_piece           p;
        t_piece           claimed [$];
        left  = len;
        limit = int'(pieces);
        if (limit == 0 || limit > MAX_PIECES_DEF) limit = MAX_PIECES_DEF;
        n    = 0;
        done = 1'b0;
        for (int w = 0; w < MAP_WORDS_DEF && !done; w++) begin
            while (!(&used_map[w]) && !done) begin
                b = 0;
                while (used_map[w][b]) b++;
                idx   = 32'(w * WORD_BITS + b);
                piece = (left < LEN_W'(cur_buffer_size)) ? left : LEN_W'(cur_buffer_size);
                used_map[w][b] = 1'b1;
                free_buffers--;
                left = left - piece;
                p.granted   = 1'b1;
                p.index     = idx[INDEX_W-1:0];
                p.address   = cur_pool_base + ADDR_W'(cur_header_ofs)
                              + ADDR_W'(cur_buffer_size) * idx;
                p.length    = piece[SIZE_W-1:0];
                p.remaining = left;
                p.last      = 1'b0;
                n++;
                if (left == 0 || n >= limit) done = 1'b1;
                claimed.push_back(p);
            end
        end
        if (n == 0) begin
            p = '0;
            p.remaining = left;
            claimed.push_back(p);
        end
        claimed[claimed.size()-1].last = 1'b1;
        if (record) begin
            foreach (claimed[i]) pending_pieces.push_back(claimed[i]);
        end
    endtask

    // Offer one request, with random gaps, and predict it at the transfer
    task automatic send_request(input logic [LEN_W-1:0] len, input logic [LIMIT_W-1:0] pieces,
                                input logic typed, input t_piece want);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {1'b0, pieces, len};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        claim_buffers(len, pieces, !typed);
        if (typed) pending_pieces.push_back(want);
        requests_sent++;
    endtask

    // Leave valid high after the transfer; the next action lowers it
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_POOL_BASE:     cur_pool_base   = data;
            CFG_HEADER_OFFSET: cur_header_ofs  = data[OFS_W-1:0];
            CFG_BUFFER_SIZE:   cur_buffer_size = data[SIZE_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Stop offering, wait for every expected piece, then let the pipeline settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        i_cfg_valid   <= 1'b0;
        @(posedge i_clk);
        while (pending_pieces.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_request();
        logic [LEN_W-1:0]   len;
        logic [LIMIT_W-1:0] pieces;
        int                 r;
        case ($urandom_range(9))
            0:       len = '0;
            1, 2:    len = $urandom;
            3, 4, 5: len = $urandom_range(1, cur_buffer_size);
            6, 7:    len = LEN_W'(cur_buffer_size) * LEN_W'($urandom_range(1, 4));
            default: len = $urandom_range(0, cur_buffer_size * 6);
        endcase
        r = $urandom_range(99);
        if (r < 75)      pieces = LIMIT_W'($urandom_range(1, 3));
        else if (r < 93) pieces = LIMIT_W'($urandom_range(4, 16));
        else             pieces = LIMIT_W'($urandom_range(17, MAX_PIECES_DEF));
        // Run the map dry in the middle of a request once it is nearly full
        if (!fill_forced && free_buffers > 0 && free_buffers < MAX_PIECES_DEF) begin
            len         = '1;
            pieces      = LIMIT_W'(MAX_PIECES_DEF);
            fill_forced = 1'b1;
        end
        send_request(len, pieces, 1'b0, '0);
    endtask

    task automatic random_config();
        drain_results();
        write_register(CFG_POOL_BASE, $urandom);
        write_register(CFG_HEADER_OFFSET, $urandom_range(0, 16'hFFFF));
        if ($urandom_range(1)) write_register(CFG_BUFFER_SIZE, $urandom_range(1, 64));
        else                   write_register(CFG_BUFFER_SIZE, $urandom_range(1, 1 << 20));
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            error_count++;
            $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $time, name, want_v, got_v);
        end
    endtask

    // Receiver: random back-pressure, plus one long hold that fills the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready  <= 1'b0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            m_axis_tready  <= 1'b0;
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_piece got;
        t_piece want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.granted   = m_axis_tuser[0];
            got.index     = m_axis_tdata[7:0];
            got.address   = m_axis_tdata[39:8];
            got.length    = m_axis_tdata[60:40];
            got.remaining = m_axis_tdata[92:61];
            got.last      = m_axis_tlast;
            if (pending_pieces.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: expected none, got %p", $time, got);
            end else begin
                want = pending_pieces.pop_front();
                check_field("granted", 32'(want.granted), 32'(got.granted));
                check_field("buffer_index", 32'(want.index), 32'(got.index));
                check_field("buffer_address", want.address, got.address);
                check_field("piece_length", 32'(want.length), 32'(got.length));
                check_field("remaining_length", want.remaining, got.remaining);
                check_field("last", 32'(want.last), 32'(got.last));
                if (want.granted) grants_checked++;
                else              full_replies++;
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("Timeout with %0d results outstanding", pending_pieces.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_POOL_BASE;
        i_cfg_data    <= '0;
        long_hold_req <= 1'b0;
        rx_idle_pct   <= 46;
        tx_idle_pct     = 35;
        error_count     = 0;
        requests_sent   = 0;
        grants_checked  = 0;
        full_replies    = 0;
        cfg_writes      = 0;
        fill_forced     = 1'b0;
        free_buffers    = POOL_BUFFERS;
        cur_pool_base   = '0;
        cur_header_ofs  = '0;
        cur_buffer_size = BUFFER_SIZE_RST;
        foreach (used_map[w]) used_map[w] = '0;

        // Directed table: reset defaults, extremes, wrap-around, tiny buffers
        directed_rows.push_back('{ROW_REQUEST, '0, 32'd0, 7'd1, 1'b1,
                                  '{1'b1, 8'd0, 32'd0, 21'd0, 32'd0, 1'b1}});
        directed_rows.push_back('{ROW_REQUEST, '0, 32'hFFFF_FFFF, 7'd1, 1'b1,
                                  '{1'b1, 8'd1, 32'd4096, 21'd4096, 32'hFFFF_EFFF, 1'b1}});
        directed_rows.push_back('{ROW_REQUEST, '0, 32'd4096, 7'd64, 1'b1,
                                  '{1'b1, 8'd2, 32'd8192, 21'd4096, 32'd0, 1'b1}});
        directed_rows.push_back('{ROW_REQUEST, '0, 32'd10000, 7'd2, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, 32'd12289, 7'd5, 1'b0, '0});
        directed_rows.push_back('{ROW_REGISTER, CFG_POOL_BASE, 32'hFFFF_FFFF, 7'd0, 1'b0, '0});
        directed_rows.push_back('{ROW_REGISTER, CFG_HEADER_OFFSET, 32'h0000_FFFF, 7'd0, 1'b0,
                                  '0});
        directed_rows.push_back('{ROW_REGISTER, CFG_BUFFER_SIZE, 32'h0010_0000, 7'd0, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, 32'h0010_0000, 7'd1, 1'b1,
                                  '{1'b1, 8'd9, 32'h0090_FFFE, 21'h10_0000, 32'd0, 1'b1}});
        directed_rows.push_back('{ROW_REQUEST, '0, 32'hFFFF_FFFF, 7'd3, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, 32'h0010_0001, 7'd64, 1'b0, '0});
        directed_rows.push_back('{ROW_REGISTER, CFG_BUFFER_SIZE, 32'd1, 7'd0, 1'b0, '0});
        directed_rows.push_back('{ROW_REGISTER, CFG_UNUSED, 32'hDEAD_BEEF, 7'd0, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, 32'd5, 7'd64, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, 32'd3, 7'd2, 1'b0, '0});
        directed_rows.push_back('{ROW_REGISTER, CFG_POOL_BASE, 32'h1000_0000, 7'd0, 1'b0, '0});
        directed_rows.push_back('{ROW_REGISTER, CFG_HEADER_OFFSET, 32'h0000_0040, 7'd0, 1'b0,
                                  '0});
        directed_rows.push_back('{ROW_REGISTER, CFG_BUFFER_SIZE, 32'd2048, 7'd0, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, 32'd0, 7'd64, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, 32'd2047, 7'd1, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, 32'd2048, 7'd2, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, 32'd2049, 7'd3, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, 32'd8191, 7'd63, 1'b0, '0});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase one: sender idles lightly, receiver more
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REGISTER) begin
                drain_results();
                write_register(directed_rows[i].reg_index, directed_rows[i].value);
            end else begin
                send_request(directed_rows[i].value, directed_rows[i].pieces,
                             directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Hold the receiver off while requests keep coming
        random_config();
        long_hold_req <= 1'b1;
        repeat (PHASE_ITEMS) random_request();

        // Phase two: pacing swapped
        random_config();
        tx_idle_pct = 46;
        rx_idle_pct <= 35;
        repeat (PHASE_ITEMS) random_request();

        // Phase three: full rate on both sides
        random_config();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        repeat (PHASE_ITEMS) random_request();

        drain_results();
        $display("Sent %0d requests; checked %0d buffer grants and %0d map-full replies",
                 requests_sent, grants_checked, full_replies);
        $display("%0d register writes, three pacing phases, map run dry mid-request: %0d",
                 cfg_writes, fill_forced);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
